// ----- hdl/first_fit_segment_allocator_macros.svh -----
// Assertion macros used by the checker file ffsa_checker.sv.
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define FFSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FFSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/ffsa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffsa_pkg
// Types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;
    localparam int ADDR_W = 48;
    localparam int SIZE_W = 40;
    localparam int ST_W   = 3;
    localparam logic [ADDR_W-1:0] RESET_HEAP_BASE  = 48'h20_0000_0000;
    localparam logic [SIZE_W-1:0] RESET_HEAP_LIMIT = 40'h01_0000_0000;
    localparam int INIT_PAGES = 160;
    localparam int MIN_ALLOC  = 16;

    typedef enum logic [1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_FREE    = 2'd1,
        FUNC_REALLOC = 2'd2,
        FUNC_INIT    = 2'd3
    } func_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NULLFREE = 3'd2,
        ST_DOUBLE   = 3'd3,
        ST_UNKNOWN  = 3'd4,
        ST_NOSPACE  = 3'd5
    } status_t;

    typedef enum logic {
        CFG_HEAP_BASE  = 1'b0,
        CFG_HEAP_LIMIT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        func;
        logic [SIZE_W-1:0] req_size;
        logic [ADDR_W-1:0] addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic [ST_W-1:0]   status;
        logic [SIZE_W-1:0] copy_bytes;
    } rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
        logic              is_free;
    } seg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FIND_RD,
        S_FIND_CHK,
        S_FIT_RD,
        S_FIT_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT,
        S_APPEND,
        S_REL_RD,
        S_REL_CHK,
        S_DONE
    } state_t;
endpackage

// ----- hdl/ffsa_if.sv -----
// ----------------------------------------------------------------------------
// ffsa_req_if / ffsa_rsp_if / ffsa_cfg_if
// Valid-ready channels of the allocator.
// ----------------------------------------------------------------------------
interface ffsa_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [39:0]       req_size;
    logic [47:0]       addr;
    modport source (output valid, func, req_size, addr, input ready);
    modport sink (input valid, func, req_size, addr, output ready);
endinterface

interface ffsa_rsp_if;
    logic              valid;
    logic              ready;
    logic [47:0]       result_addr;
    logic [2:0]        status;
    logic [39:0]       copy_bytes;
    modport source (output valid, result_addr, status, copy_bytes, input ready);
    modport sink (input valid, result_addr, status, copy_bytes, output ready);
endinterface

interface ffsa_cfg_if;
    logic              valid;
    logic              ready;
    logic [0:0]        index;
    logic [47:0]       data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/ffsa_seg_ram.sv -----
// ----------------------------------------------------------------------------
// ffsa_seg_ram
// Segment table memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffsa_seg_ram #(
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  ffsa_pkg::seg_t           wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output ffsa_pkg::seg_t           rdata
);
    import ffsa_pkg::*;

    seg_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/first_fit_segment_allocator.sv -----
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit heap segment allocator over an address-ordered segment table.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request beat is accepted only while
// the block is idle and no result beat is waiting, and input ready rises
// again in the cycle after the result beat is taken. The table lives in a
// memory with one registered read port, so each segment visited takes a read
// state and then a state that uses the read data: alloc scans up to
// MAX_SEGMENTS entries, a split moves every later entry up by one, and
// realloc with a move adds a pointer search before and after. Reinitialize
// goes from dispatch straight to the result state; entry zero is then held
// in registers until entry zero is next written.
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 32,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    ffsa_cfg_if.sink   cfg,
    ffsa_req_if.sink   req,
    ffsa_rsp_if.source rsp
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int PW = $clog2(PAGE_BYTES);
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);
    localparam logic [49:0] HDR = 50'(HEADER_BYTES);
    localparam logic [49:0] INIT_LEN = 50'(INIT_PAGES) * 50'(PAGE_BYTES);
    localparam logic [49:0] INIT_SPAN =
        50'(((INIT_PAGES * PAGE_BYTES + HEADER_BYTES + PAGE_BYTES - 1) / PAGE_BYTES)
            * PAGE_BYTES);

    function automatic logic [49:0] page_up(input logic [49:0] x);
        logic [49:0] s;
        s = x + 50'(PAGE_BYTES - 1);
        return {s[49:PW], {PW{1'b0}}};
    endfunction

    logic [ADDR_W-1:0] base_reg;
    logic [SIZE_W-1:0] limit_reg;
    logic [ADDR_W-1:0] top_reg, top_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    state_t            state_reg, state_next;
    req_t              rq_reg, rq_next;
    rsp_t              out_reg, out_next;
    logic              ov_reg, ov_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [IW-1:0]     hit_reg, hit_next;
    logic [SIZE_W-1:0] keep_reg, keep_next, old_reg, old_next;
    logic              mv_reg, mv_next;
    seg_t              cur_reg, cur_next;
    logic              e0v_reg, e0v_next;
    seg_t              e0_reg, e0_next;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    seg_t          wdata, rdata_m, rdata;
    logic [IW-1:0] rlast_reg;

    ffsa_seg_ram #(.DEPTH(MAX_SEGMENTS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata_m)
    );

    // Entry zero override after reset or reinitialize, until first written.
    assign rdata = (e0v_reg && rlast_reg == '0) ? e0_reg : rdata_m;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE) && !ov_reg;
    assign rsp.valid = ov_reg;
    assign rsp.result_addr = out_reg.result_addr;
    assign rsp.status = out_reg.status;
    assign rsp.copy_bytes = out_reg.copy_bytes;

    logic [ADDR_W-1:0] uptr;
    logic [49:0] at_w, top_w, lim_w, sum_w;
    logic [IW-1:0] i_ix;
    assign i_ix = i_reg[IW-1:0];
    assign uptr = rq_reg.addr - ADDR_W'(HEADER_BYTES);
    assign at_w = page_up({2'b0, top_reg});
    assign top_w = at_w + page_up({10'b0, keep_reg} + HDR);
    assign lim_w = {2'b0, base_reg} + {10'b0, limit_reg};
    assign sum_w = {10'b0, cur_reg.size};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= RESET_HEAP_BASE;
            limit_reg <= RESET_HEAP_LIMIT;
            top_reg   <= RESET_HEAP_BASE + ADDR_W'(INIT_SPAN);
            cnt_reg   <= CW'(1);
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            e0v_reg   <= 1'b1;
            e0_reg    <= '{RESET_HEAP_BASE, SIZE_W'(INIT_LEN), 1'b1};
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg_idx_t'(cfg.index))
                    CFG_HEAP_BASE:  base_reg  <= cfg.data;
                    CFG_HEAP_LIMIT: limit_reg <= cfg.data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            top_reg   <= top_next;
            cnt_reg   <= cnt_next;
            state_reg <= state_next;
            ov_reg    <= ov_next;
            e0v_reg   <= e0v_next;
            e0_reg    <= e0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg    <= rq_next;
        out_reg   <= out_next;
        i_reg     <= i_next;
        hit_reg   <= hit_next;
        keep_reg  <= keep_next;
        old_reg   <= old_next;
        mv_reg    <= mv_next;
        cur_reg   <= cur_next;
        rlast_reg <= raddr;
    end

    always_comb
    begin
        logic [49:0] need;
        logic [49:0] at;
        state_next = state_reg;
        rq_next = rq_reg;
        out_next = out_reg;
        ov_next = ov_reg;
        top_next = top_reg;
        cnt_next = cnt_reg;
        i_next = i_reg;
        hit_next = hit_reg;
        keep_next = keep_reg;
        old_next = old_reg;
        mv_next = mv_reg;
        cur_next = cur_reg;
        e0v_next = e0v_reg;
        e0_next = e0_reg;
        we = 1'b0;
        waddr = i_ix;
        wdata = cur_reg;
        raddr = i_ix;
        need = '0;
        at = '0;
        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && !ov_reg)
                begin
                    rq_next = '{req.func, req.req_size, req.addr};
                    mv_next = 1'b0;
                    old_next = '0;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                out_next = '{'0, ST_OK, '0};
                keep_next = (rq_reg.req_size < SIZE_W'(MIN_ALLOC)) ?
                            SIZE_W'(MIN_ALLOC) : rq_reg.req_size;
                i_next = '0;
                unique case (func_t'(rq_reg.func))
                    FUNC_INIT:
                    begin
                        at = page_up({2'b0, base_reg});
                        e0v_next = 1'b1;
                        e0_next = '{at[ADDR_W-1:0], SIZE_W'(INIT_LEN), 1'b1};
                        cnt_next = CW'(1);
                        top_next = at[ADDR_W-1:0] + ADDR_W'(INIT_SPAN);
                        state_next = S_DONE;
                    end
                    FUNC_ALLOC:
                    begin
                        state_next = S_FIT_RD;
                    end
                    FUNC_FREE:
                    begin
                        state_next = S_FIND_RD;
                    end
                    default:
                    begin
                        if (rq_reg.addr == '0)
                        begin
                            state_next = S_FIT_RD;
                        end
                        else
                        begin
                            state_next = S_FIND_RD;
                        end
                    end
                endcase
                if ((rq_reg.func == FUNC_ALLOC || (rq_reg.func == FUNC_REALLOC &&
                     rq_reg.addr == '0)) && rq_reg.req_size == '0)
                begin
                    out_next.status = ST_ZERO;
                    state_next = S_DONE;
                end
                if (rq_reg.func == FUNC_FREE || (rq_reg.func == FUNC_REALLOC &&
                    rq_reg.addr != '0))
                begin
                    if (rq_reg.addr == '0)
                    begin
                        out_next.status = ST_NULLFREE;
                        state_next = S_DONE;
                    end
                    else if (rq_reg.addr < ADDR_W'(HEADER_BYTES))
                    begin
                        out_next.status = ST_UNKNOWN;
                        state_next = S_DONE;
                    end
                end
            end
            S_FIND_RD:
            begin
                if (i_reg >= cnt_reg)
                begin
                    out_next.status = ST_UNKNOWN;
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = i_ix;
                    state_next = S_FIND_CHK;
                end
            end
            S_FIND_CHK:
            begin
                if (rdata.addr == uptr)
                begin
                    cur_next = rdata;
                    hit_next = i_ix;
                    if (rdata.is_free)
                    begin
                        out_next.status = ST_DOUBLE;
                        state_next = S_DONE;
                    end
                    else if (rq_reg.func == FUNC_FREE || rq_reg.req_size == '0)
                    begin
                        we = 1'b1;
                        waddr = i_ix;
                        wdata = '{rdata.addr, rdata.size, 1'b1};
                        if (i_ix == '0) e0v_next = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (rdata.size >= rq_reg.req_size)
                    begin
                        out_next.result_addr = rq_reg.addr;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        mv_next = 1'b1;
                        old_next = rdata.size;
                        i_next = '0;
                        state_next = S_FIT_RD;
                    end
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_FIND_RD;
                end
            end
            S_FIT_RD:
            begin
                if (i_reg >= cnt_reg)
                begin
                    state_next = S_APPEND;
                end
                else
                begin
                    raddr = i_ix;
                    state_next = S_FIT_CHK;
                end
            end
            S_FIT_CHK:
            begin
                if (rdata.is_free && rdata.size >= rq_reg.req_size)
                begin
                    cur_next = rdata;
                    hit_next = i_ix;
                    out_next.result_addr = rdata.addr + ADDR_W'(HEADER_BYTES);
                    need = {10'b0, keep_reg} + HDR + 50'(MIN_ALLOC);
                    if (rdata.size > rq_reg.req_size && {10'b0, rdata.size} >= need &&
                        cnt_reg < MAXC)
                    begin
                        i_next = cnt_reg - CW'(1);
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        we = 1'b1;
                        waddr = i_ix;
                        wdata = '{rdata.addr, rdata.size, 1'b0};
                        if (i_ix == '0) e0v_next = 1'b0;
                        state_next = mv_reg ? S_REL_RD : S_DONE;
                        i_next = '0;
                    end
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_FIT_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (i_ix == hit_reg)
                begin
                    state_next = S_SPLIT;
                end
                else
                begin
                    raddr = i_ix;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                we = 1'b1;
                waddr = i_ix + IW'(1);
                wdata = rdata;
                i_next = i_reg - CW'(1);
                state_next = S_SHIFT_RD;
            end
            S_SPLIT:
            begin
                // The remainder is written now; the taken head follows in S_REL_RD.
                we = 1'b1;
                waddr = hit_reg + IW'(1);
                wdata = '{cur_reg.addr + ADDR_W'(keep_reg) + ADDR_W'(HEADER_BYTES),
                          cur_reg.size - keep_reg - SIZE_W'(HEADER_BYTES), 1'b1};
                cnt_next = cnt_reg + CW'(1);
                cur_next = '{cur_reg.addr, keep_reg, 1'b0};
                i_next = {1'b0, hit_reg};
                state_next = S_REL_RD;
            end
            S_APPEND:
            begin
                if (cnt_reg >= MAXC || top_w > 50'h0FFFF_FFFF_FFFF || top_w > lim_w)
                begin
                    out_next.result_addr = '0;
                    out_next.status = ST_NOSPACE;
                    state_next = S_DONE;
                end
                else
                begin
                    we = 1'b1;
                    waddr = cnt_reg[IW-1:0];
                    wdata = '{at_w[ADDR_W-1:0], keep_reg, 1'b0};
                    if (cnt_reg[IW-1:0] == '0) e0v_next = 1'b0;
                    cnt_next = cnt_reg + CW'(1);
                    top_next = top_w[ADDR_W-1:0];
                    out_next.result_addr = at_w[ADDR_W-1:0] + ADDR_W'(HEADER_BYTES);
                    i_next = '0;
                    state_next = mv_reg ? S_REL_RD : S_DONE;
                end
            end
            S_REL_RD:
            begin
                // Pending write of the split head, then, for a realloc that moves, release the old block.
                if (cur_reg.is_free == 1'b0 && i_reg == {1'b0, hit_reg} &&
                    cur_reg.size == keep_reg && cur_reg.addr + ADDR_W'(HEADER_BYTES)
                    == out_reg.result_addr && sum_w != '0 && !we)
                begin
                    we = 1'b1;
                    waddr = hit_reg;
                    wdata = cur_reg;
                    if (hit_reg == '0) e0v_next = 1'b0;
                    cur_next.is_free = 1'b1;
                    i_next = '0;
                    state_next = mv_reg ? S_REL_RD : S_DONE;
                end
                else if (!mv_reg)
                begin
                    state_next = S_DONE;
                end
                else if (i_reg >= cnt_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    raddr = i_ix;
                    state_next = S_REL_CHK;
                end
            end
            S_REL_CHK:
            begin
                if (rdata.addr == uptr)
                begin
                    we = 1'b1;
                    waddr = i_ix;
                    wdata = '{rdata.addr, rdata.size, 1'b1};
                    if (i_ix == '0) e0v_next = 1'b0;
                    out_next.copy_bytes = old_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_REL_RD;
                end
            end
            S_DONE:
            begin
                if (mv_reg && out_next.status == ST_OK)
                begin
                    out_next.copy_bytes = old_reg;
                end
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// ----- hdl/ffsa_checker.sv -----
// ----------------------------------------------------------------------------
// ffsa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_segment_allocator_macros.svh"

module ffsa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [47:0] result_addr,
    input logic [2:0]  status
);
    import ffsa_pkg::*;

    `FFSA_ASSERT_IMP(a_one_at_a_time, clk, rst_n, rsp_valid, !req_ready, "accepted during result")
    `FFSA_ASSERT_NXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready,
        "accepted twice")
    `FFSA_ASSERT_IMP(a_status_range, clk, rst_n, rsp_valid, status <= ST_NOSPACE, "bad status")
    `FFSA_ASSERT_IMP(a_null_on_err, clk, rst_n, rsp_valid && (status == ST_NOSPACE ||
        status == ST_ZERO), result_addr == '0, "nonnull on error")
    `FFSA_ASSERT_NXT(a_rsp_held, clk, rst_n, rsp_valid && !rsp_ready,
        rsp_valid && $stable(result_addr) && $stable(status), "result beat dropped")
endmodule

bind first_fit_segment_allocator ffsa_checker u_ffsa_checker (
    .clk(clk), .rst_n(rst_n), .req_valid(req.valid), .req_ready(req.ready),
    .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .result_addr(rsp.result_addr), .status(rsp.status)
);

// ----- bench/segment_alloc_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// segment_alloc_checker
// Watches the configuration, request and response channels of the
// first-fit segment allocator, keeps its own copy of the segment table,
// predicts each response and compares it field by field.
// ----------------------------------------------------------------------------
module segment_alloc_checker
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64,
    parameter int HEADER_BYTES = 32,
    parameter int PAGE_BYTES   = 4096
) (
    input  logic clk,
    input  logic rst_n,
    ffsa_cfg_if  cfg,
    ffsa_req_if  req,
    ffsa_rsp_if  rsp,
    output int   errors,
    output int   pending
);
    localparam longint unsigned MASK48 = 64'hFFFF_FFFF_FFFF;
    localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;
    localparam longint unsigned INIT_LEN = INIT_PAGES * PAGE_BYTES;

    longint unsigned heap_base_q;
    longint unsigned heap_limit_q;
    longint unsigned seg_addr [MAX_SEGMENTS];
    longint unsigned seg_size [MAX_SEGMENTS];
    bit              seg_free [MAX_SEGMENTS];
    int              seg_count;
    longint unsigned heap_top;
    rsp_t            expected_rsp [$];

    function automatic longint unsigned page_up(longint unsigned x);
        return ((x + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
    endfunction

    function automatic longint unsigned span_of(longint unsigned len);
        return page_up(len + HEADER_BYTES);
    endfunction

    function automatic void reinit_heap();
        longint unsigned at;
        at = page_up(heap_base_q);
        seg_addr[0] = at & MASK48;
        seg_size[0] = INIT_LEN;
        seg_free[0] = 1'b1;
        seg_count = 1;
        heap_top = (at + span_of(INIT_LEN)) & MASK48;
    endfunction

    function automatic int find_segment(longint unsigned p);
        if (p < HEADER_BYTES)
            return -1;
        for (int i = 0; i < seg_count; i++)
            if (seg_addr[i] == p - HEADER_BYTES)
                return i;
        return -1;
    endfunction

    function automatic status_t first_fit_alloc(longint unsigned size,
                                                output longint unsigned res);
        longint unsigned keep, at, top;
        res = 0;
        if (size == 0)
            return ST_ZERO;
        keep = (size < MIN_ALLOC) ? MIN_ALLOC : size;
        for (int i = 0; i < seg_count; i++) begin
            if (!seg_free[i] || seg_size[i] < size)
                continue;
            if (seg_size[i] > size && seg_size[i] >= keep + HEADER_BYTES + MIN_ALLOC
                && seg_count < MAX_SEGMENTS)
            begin
                for (int j = seg_count - 1; j > i; j--) begin
                    seg_addr[j+1] = seg_addr[j];
                    seg_size[j+1] = seg_size[j];
                    seg_free[j+1] = seg_free[j];
                end
                seg_addr[i+1] = (seg_addr[i] + keep + HEADER_BYTES) & MASK48;
                seg_size[i+1] = seg_size[i] - keep - HEADER_BYTES;
                seg_free[i+1] = 1'b1;
                seg_size[i] = keep;
                seg_count++;
            end
            seg_free[i] = 1'b0;
            res = (seg_addr[i] + HEADER_BYTES) & MASK48;
            return ST_OK;
        end
        if (seg_count >= MAX_SEGMENTS)
            return ST_NOSPACE;
        at = page_up(heap_top);
        top = at + span_of(keep);
        if (top > MASK48 || top > heap_base_q + heap_limit_q)
            return ST_NOSPACE;
        seg_addr[seg_count] = at;
        seg_size[seg_count] = keep & MASK40;
        seg_free[seg_count] = 1'b0;
        seg_count++;
        heap_top = top;
        res = (at + HEADER_BYTES) & MASK48;
        return ST_OK;
    endfunction

    function automatic status_t release_segment(longint unsigned p);
        int k;
        if (p == 0)
            return ST_NULLFREE;
        k = find_segment(p);
        if (k < 0)
            return ST_UNKNOWN;
        if (seg_free[k])
            return ST_DOUBLE;
        seg_free[k] = 1'b1;
        return ST_OK;
    endfunction

    function automatic rsp_t predict_response(func_t f, longint unsigned size,
                                              longint unsigned p);
        longint unsigned res, copy, old;
        status_t st;
        int k;
        res = 0;
        copy = 0;
        st = ST_OK;
        case (f)
            FUNC_ALLOC: st = first_fit_alloc(size, res);
            FUNC_FREE: st = release_segment(p);
            FUNC_REALLOC:
            begin
                if (p == 0)
                    st = first_fit_alloc(size, res);
                else if (size == 0)
                    st = release_segment(p);
                else begin
                    k = find_segment(p);
                    if (k < 0)
                        st = ST_UNKNOWN;
                    else if (seg_free[k])
                        st = ST_DOUBLE;
                    else if (seg_size[k] >= size)
                        res = p;
                    else begin
                        old = seg_size[k];
                        st = first_fit_alloc(size, res);
                        if (st == ST_OK) begin
                            copy = old;
                            k = find_segment(p);
                            if (k >= 0)
                                seg_free[k] = 1'b1;
                        end
                    end
                end
            end
            default: reinit_heap();
        endcase
        predict_response.result_addr = res[47:0];
        predict_response.status = st;
        predict_response.copy_bytes = copy[39:0];
    endfunction

    assign pending = expected_rsp.size();

    always @(posedge clk or negedge rst_n) begin
        rsp_t want;
        if (!rst_n) begin
            heap_base_q = RESET_HEAP_BASE;
            heap_limit_q = RESET_HEAP_LIMIT;
            reinit_heap();
            expected_rsp.delete();
            errors = 0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg_idx_t'(cfg.index) == CFG_HEAP_BASE)
                    heap_base_q = cfg.data & MASK48;
                else
                    heap_limit_q = cfg.data & MASK40;
            end
            if (req.valid && req.ready)
                expected_rsp.push_back(predict_response(func_t'(req.func),
                                                        req.req_size, req.addr));
            if (rsp.valid && rsp.ready) begin
                if (expected_rsp.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected response beat, actual addr %h status %0d copy %h",
                             $time, rsp.result_addr, rsp.status, rsp.copy_bytes);
                end
                else begin
                    want = expected_rsp.pop_front();
                    if (want.result_addr !== rsp.result_addr) begin
                        errors++;
                        $display("%0t: result_addr expected %h actual %h",
                                 $time, want.result_addr, rsp.result_addr);
                    end
                    if (want.status !== rsp.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                    end
                    if (want.copy_bytes !== rsp.copy_bytes) begin
                        errors++;
                        $display("%0t: copy_bytes expected %h actual %h",
                                 $time, want.copy_bytes, rsp.copy_bytes);
                    end
                end
            end
        end
    end
endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives alloc, free, realloc and reinitialize requests into the first-fit
// segment allocator under several heap settings, with random gaps and a
// long response stall, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;
    import ffsa_pkg::*;

    localparam int  RANDOM_ITEMS = 1030;
    localparam longint MAX_CYCLES = 5_000_000;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    longint cycles;
    int   issued;
    int   op_count [4];
    int   sent_total;
    int   got_total;
    bit   hold_off_req;
    bit   no_gaps;
    logic [47:0] live_ptrs [$];

    ffsa_cfg_if cfg ();
    ffsa_req_if req ();
    ffsa_rsp_if rsp ();

    first_fit_segment_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    segment_alloc_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && rsp.valid && rsp.ready) begin
            got_total <= got_total + 1;
            if (rsp.result_addr != 0) begin
                live_ptrs.push_back(rsp.result_addr);
                if (live_ptrs.size() > 96)
                    void'(live_ptrs.pop_front());
            end
        end
    end

    initial begin
        int gap;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_off_req) begin
                rsp.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off_req = 1'b0;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                rsp.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!rsp.valid);
        end
    end

    task automatic send_request(func_t f, logic [39:0] size, logic [47:0] p);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.func <= f;
        req.req_size <= size;
        req.addr <= p;
        do @(posedge clk); while (!req.ready);
        op_count[f]++;
        sent_total++;
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (got_total != sent_total) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [47:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [47:0] newest_ptr();
        return (live_ptrs.size() != 0) ? live_ptrs[$] : 48'd0;
    endfunction

    function automatic logic [47:0] pick_ptr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10 || live_ptrs.size() == 0)
            return (r < 5) ? 48'd0 : 48'({$urandom, $urandom});
        if (r < 70)
            return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
        if (r < 80)
            return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)]
                   + 48'($urandom_range(1, 64));
        return 48'({$urandom, $urandom});
    endfunction

    function automatic logic [39:0] pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return 40'd0;
        if (r < 60)
            return 40'($urandom_range(1, 256));
        if (r < 85)
            return 40'($urandom_range(257, 20000));
        if (r < 95)
            return 40'($urandom_range(20001, 800000));
        return 40'({$urandom, $urandom});
    endfunction

    task automatic random_phase(int count);
        int r;
        logic [47:0] p;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (n == count / 2 && issued == 0) begin
                hold_off_req = 1'b1;
                issued = 1;
            end
            r = $urandom_range(0, 99);
            p = pick_ptr();
            if (r < 40)
                send_request(FUNC_ALLOC, pick_size(), p);
            else if (r < 70)
                send_request(FUNC_FREE, pick_size(), p);
            else if (r < 97)
                send_request(FUNC_REALLOC, pick_size(), p);
            else
                send_request(FUNC_INIT, pick_size(), p);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        logic [47:0] p;
        rst_n = 1'b0;
        cycles = 0;
        issued = 0;
        sent_total = 0;
        got_total = 0;
        hold_off_req = 1'b0;
        no_gaps = 1'b0;
        op_count = '{0, 0, 0, 0};
        req.valid <= 1'b0;
        req.func <= FUNC_ALLOC;
        req.req_size <= '0;
        req.addr <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_HEAP_BASE;
        cfg.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(FUNC_ALLOC, 40'd0, 48'd0);
        send_request(FUNC_ALLOC, 40'd1, 48'd0);
        send_request(FUNC_ALLOC, 40'd16, 48'd0);
        send_request(FUNC_FREE, 40'd0, 48'd0);
        send_request(FUNC_FREE, 40'd0, 48'd12345);
        send_request(FUNC_FREE, 40'd0, 48'd5);
        wait_idle();
        p = newest_ptr();
        send_request(FUNC_FREE, 40'd0, p);
        send_request(FUNC_FREE, 40'd0, p);
        send_request(FUNC_REALLOC, 40'd8, p);
        send_request(FUNC_REALLOC, 40'd40, 48'd0);
        send_request(FUNC_REALLOC, 40'd8, 48'hFFFF_FFFF_FFFF);
        wait_idle();
        p = newest_ptr();
        send_request(FUNC_REALLOC, 40'd20, p);
        send_request(FUNC_REALLOC, 40'd5000, p);
        wait_idle();
        p = newest_ptr();
        send_request(FUNC_REALLOC, 40'd0, p);
        send_request(FUNC_ALLOC, 40'hFF_FFFF_FFFF, 48'd0);
        send_request(FUNC_ALLOC, 40'd700000, 48'd0);
        send_request(FUNC_ALLOC, 40'd655000, 48'd0);
        send_request(FUNC_INIT, 40'hFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(FUNC_ALLOC, 40'd655360, 48'd0);
        wait_idle();

        random_phase(RANDOM_ITEMS / 4);
        wait_idle();
        write_reg(CFG_HEAP_BASE, 48'd0);
        write_reg(CFG_HEAP_LIMIT, 48'd0);
        send_request(FUNC_INIT, 40'd0, 48'd0);
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();
        write_reg(CFG_HEAP_BASE, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_HEAP_LIMIT, 48'hFFFF_FFFF_FFFF);
        send_request(FUNC_INIT, 40'd0, 48'd0);
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();
        write_reg(CFG_HEAP_BASE, 48'({$urandom, $urandom}));
        write_reg(CFG_HEAP_LIMIT, 48'($urandom_range(0, 20'hFFFFF)));
        send_request(FUNC_INIT, 40'd0, 48'd0);
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();

        $display("Covered %0d requests: %0d alloc, %0d free, %0d realloc, %0d reinit,",
                 sent_total, op_count[FUNC_ALLOC], op_count[FUNC_FREE],
                 op_count[FUNC_REALLOC], op_count[FUNC_INIT]);
        $display("over four heap base and limit settings with a long response stall.");
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/ffsa_pkg.sv
hdl/ffsa_if.sv
hdl/ffsa_seg_ram.sv
hdl/first_fit_segment_allocator.sv
hdl/ffsa_checker.sv
bench/segment_alloc_checker.sv
bench/testbench.sv
